// ===== hdl/tft_pkg.sv =====
// Shared types and constants for the TCP flow tracker table.
// No dependencies; used by every module under hdl/.
package tft_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  TLS_HANDSHAKE  = 8'h16;
  localparam logic [7:0]  TLS_MAJOR      = 8'h03;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_VAL_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_ESTABLISHED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT         = 8'd1;
  localparam logic [CFG_VAL_W-1:0] ESTABLISHED_RST = 10'd3;
  localparam logic [CFG_VAL_W-1:0] HOT_RST         = 10'd10;

  localparam logic [1:0] LEVEL_NEW  = 2'd0;
  localparam logic [1:0] LEVEL_EST  = 2'd1;
  localparam logic [1:0] LEVEL_HOT  = 2'd2;
  localparam logic [1:0] LEVEL_NONE = 2'd3;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Parsed header as it arrives on the input stream.
  typedef struct packed {
    logic        egress;
    logic        header_complete;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        payload_present;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
  } hdr_t;

  // Classified work item handed from the front end to the back end.
  typedef struct packed {
    logic        classified;
    logic        egress;
    logic        tls_mark;
    logic [63:0] key;
    logic [15:0] set_idx;
  } item_t;

  // One result word.
  typedef struct packed {
    logic        classified;
    logic        flow_created;
    logic [1:0]  flow_level;
    logic        fast_path;
    logic        tls_optimized;
    logic [63:0] packets_seen;
    logic [63:0] fast_seen;
    logic [63:0] tls_seen;
    logic [63:0] flows_seen;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } be_state_e;

endpackage

// ===== hdl/tft_front.sv =====
// Front end: classifies headers, builds the flow key and its set index.
// Depends on tft_pkg. Two register stages, the second one holds the
// reciprocal product used for the set modulo.
module tft_front import tft_pkg::*; #(
  parameter int unsigned FLOW_ENTRIES = 4096,
  parameter int unsigned TABLE_WAYS   = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  hdr_t  in_hdr_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  localparam int unsigned NUM_SETS = FLOW_ENTRIES / TABLE_WAYS;
  localparam int unsigned RSHIFT   = 40;
  localparam longint unsigned RECIP =
    ((64'd1 << RSHIFT) + longint'(NUM_SETS) - 64'd1) / longint'(NUM_SETS);
  localparam logic [40:0] RECIP_W  = RECIP[40:0];
  localparam logic [16:0] SETS_W   = NUM_SETS[16:0];

  logic        a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  item_t       a_item_q, a_item_d, b_item_q;
  logic [15:0] a_fold_q, a_fold_d, b_fold_q;
  logic [15:0] b_quot_q;
  logic        a_move, b_load;
  logic [56:0] quot_prod;
  logic [32:0] back_prod;
  logic [31:0] fold32;

  assign b_load     = !b_valid_q || out_ready_i;
  assign a_move     = a_valid_q && b_load;
  assign in_ready_o = !a_valid_q || a_move;

  always_comb begin
    a_item_d.classified = in_hdr_i.header_complete &&
                          (in_hdr_i.ether_type == ETHERTYPE_IPV4) &&
                          (in_hdr_i.ip_protocol == PROTO_TCP);
    a_item_d.egress     = in_hdr_i.egress;
    a_item_d.tls_mark   = in_hdr_i.payload_present &&
                          (in_hdr_i.payload_first == TLS_HANDSHAKE) &&
                          (in_hdr_i.payload_second == TLS_MAJOR);
    if (in_hdr_i.egress) begin
      a_item_d.key = {in_hdr_i.dest_address, in_hdr_i.dest_port, in_hdr_i.source_port};
    end else begin
      a_item_d.key = {in_hdr_i.source_address, in_hdr_i.source_port, in_hdr_i.dest_port};
    end
    a_item_d.set_idx = '0;
    fold32   = a_item_d.key[31:0] ^ a_item_d.key[63:32];
    a_fold_d = fold32[15:0] ^ fold32[31:16];
  end

  assign a_valid_d = in_ready_o ? in_valid_i : a_valid_q;
  assign b_valid_d = b_load ? a_valid_q : b_valid_q;

  // fold / NUM_SETS by reciprocal, exact for 16-bit folds
  assign quot_prod = 57'(a_fold_q) * 57'(RECIP_W);
  assign back_prod = 33'(b_quot_q) * 33'(SETS_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      a_item_q <= a_item_d;
      a_fold_q <= a_fold_d;
    end
    if (b_load) begin
      b_item_q <= a_item_q;
      b_fold_q <= a_fold_q;
      b_quot_q <= quot_prod[RSHIFT+15:RSHIFT];
    end
  end

  always_comb begin
    out_item_o         = b_item_q;
    out_item_o.set_idx = b_fold_q - back_prod[15:0];
  end
  assign out_valid_o = b_valid_q;

endmodule

// ===== hdl/tft_fifo.sv =====
// Two-word queue between the front end and the back end.
// Depends on tft_pkg for the item type.
module tft_fifo import tft_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  ready_o,
  input  item_t push_item_i,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/tft_back.sv =====
// Back end: set-associative flow table with LRU ranks, totals, result register.
// Depends on tft_pkg. One memory row per set holds all ways of that set.
module tft_back import tft_pkg::*; #(
  parameter int unsigned FLOW_ENTRIES = 4096,
  parameter int unsigned TABLE_WAYS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CFG_VAL_W-1:0] est_after_i,
  input  logic [CFG_VAL_W-1:0] hot_after_i,
  input  logic                 in_valid_i,
  output logic                 in_pop_o,
  input  item_t                in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output result_t              out_res_o
);

  localparam int unsigned NUM_SETS = FLOW_ENTRIES / TABLE_WAYS;
  localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int unsigned RW = $clog2(TABLE_WAYS + 1);
  localparam logic [SW-1:0] LAST_SET = SW'(NUM_SETS - 1);
  localparam logic [RW-1:0] ALL_WAYS = RW'(TABLE_WAYS);

  typedef struct packed {
    logic          valid;
    logic [WW-1:0] age;
    logic [63:0]   key;
    logic [31:0]   count;
    logic [1:0]    level;
    logic          tls;
  } way_t;

  typedef way_t [TABLE_WAYS-1:0] row_t;

  row_t          mem_q [NUM_SETS];
  row_t          rd_q, wr_row;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;

  be_state_e     state_q, state_d;
  logic [SW-1:0] clr_q;
  item_t         cur_q;
  logic [63:0]   pkts_q, fast_q, tls_q, flows_q;
  logic          out_valid_q;
  result_t       out_q, res_d;
  logic          out_free, pop, load_out;

  logic          hit_q, hit_d;
  logic [WW-1:0] hit_way_q, hit_way_d, ins_way_q, ins_way_d;
  logic [RW-1:0] ins_rank_q, ins_rank_d;
  logic          any_inv;
  logic [WW-1:0] inv_way, old_way;
  logic [WW-1:0] best_age;

  logic [WW-1:0] slot;
  logic [RW-1:0] rank;
  logic [31:0]   cnt_new;
  logic [1:0]    lvl_new;
  logic          upd_we;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == LAST_SET) state_d = ST_IDLE;
      ST_IDLE:   if (pop && in_item_i.classified) state_d = ST_LOOK;
      ST_LOOK:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop      = in_valid_i && out_free;
        load_out = pop && !in_item_i.classified;
      end
      ST_UPDATE: load_out = 1'b1;
      default: ;
    endcase
  end
  assign in_pop_o = pop;

  // tag compare and replacement choice on the row just read
  always_comb begin
    hit_d     = 1'b0;
    hit_way_d = '0;
    any_inv   = 1'b0;
    inv_way   = '0;
    for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
      if (rd_q[w].valid && rd_q[w].key == cur_q.key) begin
        hit_d     = 1'b1;
        hit_way_d = WW'(w);
      end
      if (!rd_q[w].valid) begin
        any_inv = 1'b1;
        inv_way = WW'(w);
      end
    end
    best_age = '0;
    old_way  = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (rd_q[w].age > best_age) begin
        best_age = rd_q[w].age;
        old_way  = WW'(w);
      end
    end
    ins_way_d  = any_inv ? inv_way : old_way;
    ins_rank_d = any_inv ? ALL_WAYS : RW'(best_age);
  end

  // row update, counters and result
  always_comb begin
    slot    = hit_q ? hit_way_q : ins_way_q;
    rank    = hit_q ? RW'(rd_q[hit_way_q].age) : ins_rank_q;
    wr_row  = rd_q;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (WW'(w) != slot && rd_q[w].valid && RW'(rd_q[w].age) < rank) begin
        wr_row[w].age = rd_q[w].age + WW'(1);
      end
    end
    wr_row[slot].age = '0;

    cnt_new = rd_q[slot].count;
    lvl_new = rd_q[slot].level;
    if (!cur_q.egress && rd_q[slot].count != COUNT_MAX) begin
      cnt_new = rd_q[slot].count + 32'd1;
    end
    if (!cur_q.egress) begin
      if (cnt_new > 32'(hot_after_i) && lvl_new < LEVEL_HOT) begin
        lvl_new = LEVEL_HOT;
      end else if (cnt_new > 32'(est_after_i) && lvl_new < LEVEL_EST) begin
        lvl_new = LEVEL_EST;
      end
    end

    res_d = '0;
    res_d.flow_level   = LEVEL_NONE;
    res_d.packets_seen = pkts_q;
    res_d.fast_seen    = fast_q;
    res_d.tls_seen     = tls_q;
    res_d.flows_seen   = flows_q;
    upd_we = 1'b0;
    if (state_q == ST_UPDATE) begin
      res_d.classified   = 1'b1;
      res_d.packets_seen = pkts_q + 64'd1;
      if (hit_q) begin
        upd_we              = 1'b1;
        wr_row[slot].count  = cnt_new;
        wr_row[slot].level  = lvl_new;
        res_d.flow_level    = lvl_new;
        res_d.fast_path     = (lvl_new == LEVEL_HOT);
        res_d.tls_optimized = (lvl_new == LEVEL_HOT) && rd_q[slot].tls;
      end else if (!cur_q.egress) begin
        upd_we             = 1'b1;
        wr_row[slot].valid = 1'b1;
        wr_row[slot].key   = cur_q.key;
        wr_row[slot].count = 32'd1;
        wr_row[slot].level = LEVEL_NEW;
        wr_row[slot].tls   = cur_q.tls_mark;
        res_d.flow_created = 1'b1;
        res_d.flow_level   = LEVEL_NEW;
      end
      res_d.fast_seen  = fast_q + 64'(res_d.fast_path);
      res_d.tls_seen   = tls_q + 64'(res_d.tls_optimized);
      res_d.flows_seen = flows_q + 64'(res_d.flow_created);
    end
  end

  assign mem_we    = (state_q == ST_CLEAR) || upd_we;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : cur_q.set_idx[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= (state_q == ST_CLEAR) ? row_t'('0) : wr_row;
    end
    if (pop && in_item_i.classified) begin
      rd_q  <= mem_q[in_item_i.set_idx[SW-1:0]];
      cur_q <= in_item_i;
    end
    if (state_q == ST_LOOK) begin
      hit_q      <= hit_d;
      hit_way_q  <= hit_way_d;
      ins_way_q  <= ins_way_d;
      ins_rank_q <= ins_rank_d;
    end
    if (load_out) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pkts_q      <= '0;
      fast_q      <= '0;
      tls_q       <= '0;
      flows_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + SW'(1);
      end
      if (load_out) begin
        pkts_q  <= res_d.packets_seen;
        fast_q  <= res_d.fast_seen;
        tls_q   <= res_d.tls_seen;
        flows_q <= res_d.flows_seen;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== hdl/tcp_flow_tracker_table.sv =====
// Top level of the TCP flow tracker table: stream ports, threshold registers,
// front end, queue and back end. Depends on tft_pkg, tft_front, tft_fifo, tft_back.
//
// Usage:
//  - Input stream (s_axis_*): one word per parsed packet header; tuser carries
//    the direction (0 ingress, 1 egress). A word is taken when tvalid and
//    tready are both high.
//  - Output stream (m_axis_*): exactly one result word per input word, in order.
//  - Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0 established threshold, 1 hot threshold); other indexes are ignored.
//    Write only while the block is idle.
//  - Path of a classified header: 2 front-end stages, queue, table read,
//    compare, update/result register.
//  - Back end: each classified header takes a table read-modify-write (read,
//    compare, write) before the next header is popped; a header that is not
//    IPv4/TCP goes straight to the result register. The front end takes one word
//    per cycle until the two-word queue fills.
//  - Reset: the totals clear at once; the table runs a clearing pass over
//    FLOW_ENTRIES / TABLE_WAYS sets (1024 by default), one set per cycle.
//    Words are buffered meanwhile and processed once the pass ends.
//  - Receiver stall: the result register holds; the back end stops, then the
//    queue and front end fill and s_axis_tready drops.
module tcp_flow_tracker_table import tft_pkg::*; #(
  parameter int unsigned FLOW_ENTRIES = 4096,
  parameter int unsigned TABLE_WAYS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // header_complete, ether_type, ip_protocol, source_address, dest_address,
  // source_port, dest_port, payload_present, payload_first, payload_second
  input  logic [143:0]         s_axis_tdata,
  // req_type
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // classified, flow_created, flow_level, fast_path, tls_optimized,
  // packets_seen, fast_seen, tls_seen, flows_seen
  output logic [263:0]         m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_VAL_W-1:0] cfg_wdata_i
);

  logic [CFG_VAL_W-1:0] est_after_q, hot_after_q;
  hdr_t    hdr;
  item_t   fe_item, q_item;
  logic    fe_valid, fe_ready, q_valid, q_pop;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_after_q <= ESTABLISHED_RST;
      hot_after_q <= HOT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ESTABLISHED: est_after_q <= cfg_wdata_i;
        REG_HOT:         hot_after_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // unpack the input word, lowest field first
  always_comb begin
    hdr.egress          = s_axis_tuser[0];
    hdr.header_complete = s_axis_tdata[0];
    hdr.ether_type      = s_axis_tdata[16:1];
    hdr.ip_protocol     = s_axis_tdata[24:17];
    hdr.source_address  = s_axis_tdata[56:25];
    hdr.dest_address    = s_axis_tdata[88:57];
    hdr.source_port     = s_axis_tdata[104:89];
    hdr.dest_port       = s_axis_tdata[120:105];
    hdr.payload_present = s_axis_tdata[121];
    hdr.payload_first   = s_axis_tdata[129:122];
    hdr.payload_second  = s_axis_tdata[137:130];
  end

  tft_front #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .TABLE_WAYS   (TABLE_WAYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_hdr_i    (hdr),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_item_o  (fe_item)
  );

  tft_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fe_valid),
    .ready_o     (fe_ready),
    .push_item_i (fe_item),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (q_item)
  );

  tft_back #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .TABLE_WAYS   (TABLE_WAYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .est_after_i (est_after_q),
    .hot_after_i (hot_after_q),
    .in_valid_i  (q_valid),
    .in_pop_o    (q_pop),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // pack the result word, lowest field first
  assign m_axis_tdata = {2'b00, res.flows_seen, res.tls_seen, res.fast_seen,
                         res.packets_seen, res.tls_optimized, res.fast_path,
                         res.flow_level, res.flow_created, res.classified};

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for tcp_flow_tracker_table: drives parsed headers, predicts
// each result word with an in-bench flow table model and compares field by field.
// Depends on tft_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module testbench;
  import tft_pkg::*;

  localparam int unsigned FLOW_ENTRIES = 4096;
  localparam int unsigned TABLE_WAYS   = 4;
  localparam int unsigned NUM_SETS     = FLOW_ENTRIES / TABLE_WAYS;

  // Expected result word, unpacked for field-wise compare.
  typedef struct {
    logic        classified;
    logic        flow_created;
    logic [1:0]  flow_level;
    logic        fast_path;
    logic        tls_optimized;
    logic [63:0] packets_seen;
    logic [63:0] fast_seen;
    logic [63:0] tls_seen;
    logic [63:0] flows_seen;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [143:0]         s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [263:0]         m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_VAL_W-1:0] cfg_wdata_i = '0;

  tcp_flow_tracker_table #(
    .FLOW_ENTRIES(FLOW_ENTRIES),
    .TABLE_WAYS  (TABLE_WAYS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow flow table and totals.
  logic        tbl_valid [FLOW_ENTRIES];
  logic [63:0] tbl_key   [FLOW_ENTRIES];
  logic [31:0] tbl_count [FLOW_ENTRIES];
  logic [1:0]  tbl_level [FLOW_ENTRIES];
  logic        tbl_tls   [FLOW_ENTRIES];
  logic [1:0]  tbl_rank  [FLOW_ENTRIES];
  logic [63:0] sum_packets, sum_fast, sum_tls, sum_flows;
  logic [9:0]  thr_established, thr_hot;

  verdict_t pending_results[$];
  int       n_errors = 0;
  bit       idle_on = 1'b1;   // random gaps/stalls enabled

  // Recent ingress flow headers kept for hits and egress replies.
  hdr_t known_flows[$];

  function automatic int unsigned set_index(logic [63:0] key);
    logic [63:0] f;
    f = key ^ (key >> 32);
    f = (f ^ (f >> 16)) & 64'hFFFF;
    return int'(f % NUM_SETS);
  endfunction

  // Promote 'slot' to most recent; valid ways fresher than it age by one.
  function automatic void promote(int unsigned base, int unsigned slot, int unsigned old_rank);
    for (int unsigned w = 0; w < TABLE_WAYS; w++) begin
      if (base + w != slot && tbl_valid[base+w] && tbl_rank[base+w] < old_rank)
        tbl_rank[base+w]++;
    end
    tbl_rank[slot] = '0;
  endfunction

  function automatic verdict_t classify_header(hdr_t h);
    verdict_t    v;
    logic [63:0] key;
    int unsigned base, slot, best, rank;
    int          hit;
    v = '{classified: 1'b0, flow_created: 1'b0, flow_level: LEVEL_NONE,
          fast_path: 1'b0, tls_optimized: 1'b0, packets_seen: '0,
          fast_seen: '0, tls_seen: '0, flows_seen: '0};
    if (h.header_complete && h.ether_type == ETHERTYPE_IPV4 && h.ip_protocol == PROTO_TCP) begin
      v.classified = 1'b1;
      key = h.egress ? {h.dest_address, h.dest_port, h.source_port}
                     : {h.source_address, h.source_port, h.dest_port};
      base = set_index(key) * TABLE_WAYS;
      hit = -1;
      for (int unsigned w = 0; w < TABLE_WAYS; w++) begin
        if (hit < 0 && tbl_valid[base+w] && tbl_key[base+w] == key) hit = base + w;
      end
      if (hit >= 0) begin
        promote(base, hit, tbl_rank[hit]);
        if (!h.egress) begin
          if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
          if (tbl_count[hit] > thr_hot && tbl_level[hit] < LEVEL_HOT)
            tbl_level[hit] = LEVEL_HOT;
          else if (tbl_count[hit] > thr_established && tbl_level[hit] < LEVEL_EST)
            tbl_level[hit] = LEVEL_EST;
        end
        v.flow_level = tbl_level[hit];
        if (tbl_level[hit] == LEVEL_HOT) begin
          v.fast_path = 1'b1;
          sum_fast++;
          if (tbl_tls[hit]) begin
            v.tls_optimized = 1'b1;
            sum_tls++;
          end
        end
      end else if (!h.egress) begin
        slot = FLOW_ENTRIES;
        rank = TABLE_WAYS;
        for (int unsigned w = 0; w < TABLE_WAYS; w++) begin
          if (slot == FLOW_ENTRIES && !tbl_valid[base+w]) slot = base + w;
        end
        if (slot == FLOW_ENTRIES) begin
          // full set: evict the least recent way
          best = 0;
          slot = base;
          for (int unsigned w = 0; w < TABLE_WAYS; w++) begin
            if (tbl_rank[base+w] > best) begin
              best = tbl_rank[base+w];
              slot = base + w;
            end
          end
          rank = best;
        end
        promote(base, slot, rank);
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = key;
        tbl_count[slot] = 32'd1;
        tbl_level[slot] = LEVEL_NEW;
        tbl_tls[slot]   = h.payload_present && h.payload_first == TLS_HANDSHAKE
                          && h.payload_second == TLS_MAJOR;
        v.flow_created  = 1'b1;
        v.flow_level    = LEVEL_NEW;
        sum_flows++;
      end
      sum_packets++;
    end
    v.packets_seen = sum_packets;
    v.fast_seen    = sum_fast;
    v.tls_seen     = sum_tls;
    v.flows_seen   = sum_flows;
    return v;
  endfunction

  // Send one header word; random gap bursts before it while idling is on.
  task automatic send_header(hdr_t h);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= h.egress;
    // first field in the lowest bits
    s_axis_tdata  <= {6'b0, h.payload_second, h.payload_first, h.payload_present,
                      h.dest_port, h.source_port, h.dest_address, h.source_address,
                      h.ip_protocol, h.ether_type, h.header_complete};
    pending_results.push_back(classify_header(h));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  // Receiver: stall bursts, compare each accepted result word.
  initial begin
    verdict_t exp_v;
    verdict_t got;
    int       stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        {got.packets_seen, got.fast_seen, got.tls_seen, got.flows_seen} = '0;
        got.classified    = m_axis_tdata[0];
        got.flow_created  = m_axis_tdata[1];
        got.flow_level    = m_axis_tdata[3:2];
        got.fast_path     = m_axis_tdata[4];
        got.tls_optimized = m_axis_tdata[5];
        got.packets_seen  = m_axis_tdata[69:6];
        got.fast_seen     = m_axis_tdata[133:70];
        got.tls_seen      = m_axis_tdata[197:134];
        got.flows_seen    = m_axis_tdata[261:198];
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          n_errors++;
        end else begin
          exp_v = pending_results.pop_front();
          if (got.classified !== exp_v.classified) begin
            $error("classified exp %0d got %0d", exp_v.classified, got.classified); n_errors++;
          end
          if (got.flow_created !== exp_v.flow_created) begin
            $error("flow_created exp %0d got %0d", exp_v.flow_created, got.flow_created);
            n_errors++;
          end
          if (got.flow_level !== exp_v.flow_level) begin
            $error("flow_level exp %0d got %0d", exp_v.flow_level, got.flow_level); n_errors++;
          end
          if (got.fast_path !== exp_v.fast_path) begin
            $error("fast_path exp %0d got %0d", exp_v.fast_path, got.fast_path); n_errors++;
          end
          if (got.tls_optimized !== exp_v.tls_optimized) begin
            $error("tls_optimized exp %0d got %0d", exp_v.tls_optimized, got.tls_optimized);
            n_errors++;
          end
          if (got.packets_seen !== exp_v.packets_seen) begin
            $error("packets_seen exp %0d got %0d", exp_v.packets_seen, got.packets_seen);
            n_errors++;
          end
          if (got.fast_seen !== exp_v.fast_seen) begin
            $error("fast_seen exp %0d got %0d", exp_v.fast_seen, got.fast_seen); n_errors++;
          end
          if (got.tls_seen !== exp_v.tls_seen) begin
            $error("tls_seen exp %0d got %0d", exp_v.tls_seen, got.tls_seen); n_errors++;
          end
          if (got.flows_seen !== exp_v.flows_seen) begin
            $error("flows_seen exp %0d got %0d", exp_v.flows_seen, got.flows_seen); n_errors++;
          end
        end
      end
      // stall pattern for the next edge
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Register write; only between phases with the block drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_VAL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_ESTABLISHED) thr_established = val;
    else if (idx == REG_HOT) thr_hot = val;
  endtask

  task automatic drain();
    end_stream();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic hdr_t tcp_header(logic egress);
    hdr_t h;
    h.egress          = egress;
    h.header_complete = 1'b1;
    h.ether_type      = ETHERTYPE_IPV4;
    h.ip_protocol     = PROTO_TCP;
    h.source_address  = $urandom;
    h.dest_address    = $urandom;
    h.source_port     = 16'($urandom);
    h.dest_port       = 16'($urandom);
    h.payload_present = 1'($urandom_range(0, 1));
    h.payload_first   = $urandom_range(0, 1) ? TLS_HANDSHAKE : 8'($urandom);
    h.payload_second  = $urandom_range(0, 1) ? TLS_MAJOR : 8'($urandom);
    return h;
  endfunction

  // Egress reply to an ingress flow: addresses and ports swapped.
  function automatic hdr_t reply_of(hdr_t h);
    hdr_t r;
    r = h;
    r.egress         = 1'b1;
    r.source_address = h.dest_address;
    r.dest_address   = h.source_address;
    r.source_port    = h.dest_port;
    r.dest_port      = h.source_port;
    return r;
  endfunction

  // Directed: field extremes, non-TCP filters, TLS marking, promotion to hot.
  task automatic test_directed();
    hdr_t h;
    hdr_t f;
    h = tcp_header(1'b0);
    h.header_complete = 1'b0; send_header(h);
    h = tcp_header(1'b0); h.ether_type = 16'h86DD; send_header(h);
    h = tcp_header(1'b0); h.ip_protocol = 8'd17; send_header(h);
    h = tcp_header(1'b1); send_header(h);               // egress miss
    h = tcp_header(1'b0);
    h.source_address = '0; h.dest_address = '0; h.source_port = '0; h.dest_port = '0;
    h.payload_present = 1'b0; h.payload_first = '0; h.payload_second = '0;
    send_header(h);
    h = tcp_header(1'b0);
    h.source_address = '1; h.dest_address = '1; h.source_port = '1; h.dest_port = '1;
    h.payload_present = 1'b1; h.payload_first = '1; h.payload_second = '1;
    send_header(h);
    // TLS flow driven to hot with reset thresholds
    f = tcp_header(1'b0);
    f.payload_present = 1'b1; f.payload_first = TLS_HANDSHAKE; f.payload_second = TLS_MAJOR;
    repeat (13) send_header(f);
    send_header(reply_of(f));                           // egress hit on hot flow
    known_flows.push_back(f);
    drain();
  endtask

  // Fill one set past its ways to exercise eviction and recency.
  task automatic test_set_eviction();
    hdr_t h;
    hdr_t same_set[$];
    int unsigned target;
    h = tcp_header(1'b0);
    target = set_index({h.source_address, h.source_port, h.dest_port});
    same_set.push_back(h);
    while (same_set.size() < 6) begin
      h = tcp_header(1'b0);
      h.source_port = 16'($urandom);
      if (set_index({h.source_address, h.source_port, h.dest_port}) == target)
        same_set.push_back(h);
    end
    for (int i = 0; i < 4; i++) send_header(same_set[i]);
    send_header(same_set[0]);                           // refresh way 0
    send_header(reply_of(same_set[2]));                 // egress refresh
    send_header(same_set[4]);                           // evicts least recent
    send_header(same_set[5]);
    for (int i = 0; i < 6; i++) send_header(same_set[i]);
    drain();
  endtask

  // Mostly traffic on a small pool of flows, with noise and fresh flows.
  task automatic test_random_traffic(int n_items);
    hdr_t h;
    int   sel;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        h = tcp_header(1'($urandom_range(0, 1)));
        h.header_complete = 1'($urandom_range(0, 1));
        h.ether_type = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
        h.ip_protocol = $urandom_range(0, 1) ? PROTO_TCP : 8'($urandom);
      end else if (sel < 25 || known_flows.size() == 0) begin
        h = tcp_header(1'b0);
        if (known_flows.size() < 16) known_flows.push_back(h);
        else known_flows[$urandom_range(0, 15)] = h;
      end else if (sel < 40) begin
        h = reply_of(known_flows[$urandom_range(0, known_flows.size() - 1)]);
      end else begin
        h = known_flows[$urandom_range(0, known_flows.size() - 1)];
      end
      send_header(h);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rank[i]  = '0;
    end
    {sum_packets, sum_fast, sum_tls, sum_flows} = '0;
    thr_established = ESTABLISHED_RST;
    thr_hot         = HOT_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_set_eviction();
    write_reg(REG_ESTABLISHED, '0);
    write_reg(REG_HOT, '0);
    test_random_traffic(120);
    write_reg(REG_ESTABLISHED, '1);
    write_reg(REG_HOT, '1);
    test_random_traffic(120);
    write_reg(REG_ESTABLISHED, 10'd2);
    write_reg(REG_HOT, 10'd5);
    write_reg(8'd7, 10'd1);                              // unmapped index, ignored
    test_random_traffic(140);
    idle_on = 1'b0;                                      // back-to-back finish
    test_random_traffic(100);

    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== tcp_flow_tracker_table.f =====
hdl/tft_pkg.sv
hdl/tft_front.sv
hdl/tft_fifo.sv
hdl/tft_back.sv
hdl/tcp_flow_tracker_table.sv
tb/testbench.sv
